/* rtl/mep_pkg.sv */
package mep_pkg;

	// field and register widths
	localparam int INDEX_W     = 20;
	localparam int COORD_W     = 32;
	localparam int PROD_W      = 2 * COORD_W;
	localparam int SAT_W       = PROD_W + 2;
	localparam int LIMIT_W     = 31;
	localparam int WIDTH_W     = 11;
	localparam int STEP_W      = 31;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;

	// defaults for the top level parameters
	localparam int MAX_WIDTH_DEFAULT     = 1024;
	localparam int FRACTION_BITS_DEFAULT = 28;

	// depth of the queue between front and back, a power of two
	localparam int QUEUE_DEPTH = 4;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ITERATION_LIMIT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SIDE_LEN        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_REAL_ORIGIN     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAG_ORIGIN     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_REAL_STEP       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAG_STEP       = 3'd5;

	// register reset values
	localparam logic [LIMIT_W-1:0]        ITERATION_LIMIT_RESET = 31'd1000;
	localparam logic [WIDTH_W-1:0]        SIDE_LEN_RESET        = 11'd512;
	localparam logic signed [COORD_W-1:0] ORIGIN_RESET          = -32'sd536870912;
	localparam logic [STEP_W-1:0]         STEP_RESET            = 31'd2097152;

	typedef struct packed {
		logic [LIMIT_W-1:0]        iteration_limit;
		logic [WIDTH_W-1:0]        side_len;
		logic signed [COORD_W-1:0] real_origin;
		logic signed [COORD_W-1:0] imag_origin;
		logic [STEP_W-1:0]         real_step;
		logic [STEP_W-1:0]         imag_step;
	} cfg_t;

	// one pixel handed from the front to the back
	typedef struct packed {
		logic [INDEX_W-1:0]        pixel_index;
		logic signed [COORD_W-1:0] c_re;
		logic signed [COORD_W-1:0] c_im;
	} job_t;

	// clamp a wide signed value to the coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = {{(SAT_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
		lo = {{(SAT_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
		if (v > hi) begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return v[COORD_W-1:0];
		end
	endfunction

endpackage

/* rtl/mep_if.sv */
// pixel index channel
interface mep_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [mep_pkg::INDEX_W-1:0]  pixel_index;

	modport source(output valid, output pixel_index, input ready);
	modport sink(input valid, input pixel_index, output ready);
endinterface

// result channel
interface mep_result_if;
	logic                         valid;
	logic                         ready;
	logic [mep_pkg::INDEX_W-1:0]  pixel_echo;
	logic                         escaped;

	modport source(output valid, output pixel_echo, output escaped, input ready);
	modport sink(input valid, input pixel_echo, input escaped, output ready);
endinterface

/* rtl/mep_front.sv */
module mep_front #(
	parameter int MAX_WIDTH = mep_pkg::MAX_WIDTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mep_pkg::cfg_t  cfg,
	mep_pixel_if.sink      pixels,
	output logic           job_push,
	output mep_pkg::job_t  job,
	input  logic           job_full
);

	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W  = (WW > mep_pkg::WIDTH_W) ? WW : mep_pkg::WIDTH_W;
	localparam int SQ_W   = 2 * WW;
	localparam int CHK_W  = (SQ_W > mep_pkg::INDEX_W) ? SQ_W : mep_pkg::INDEX_W;
	localparam int CNT_W  = $clog2(mep_pkg::INDEX_W);
	localparam int PRD_W  = mep_pkg::STEP_W + WW;
	localparam int SUM_W  = PRD_W + 2;
	localparam logic [CMP_W-1:0] MAX_CMP   = CMP_W'(MAX_WIDTH);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(mep_pkg::INDEX_W - 1);

	typedef enum logic [4:0] {
		F_IDLE  = 5'b00001,
		F_CHECK = 5'b00010,
		F_DIV   = 5'b00100,
		F_MUL   = 5'b01000,
		F_SUM   = 5'b10000
	} front_state_t;

	front_state_t                 state_q;
	logic [CNT_W-1:0]             step_cnt_q;
	logic [mep_pkg::INDEX_W-1:0]  idx_q;
	logic [WW-1:0]                width_q;
	logic [mep_pkg::INDEX_W-1:0]  quo_q;
	logic [WW-1:0]                rem_q;
	logic [PRD_W-1:0]             prod_re_q;
	logic [PRD_W-1:0]             prod_im_q;

	logic [CMP_W-1:0]             width_ext;
	logic [WW-1:0]                width_eff;
	logic [SQ_W-1:0]              width_sq;
	logic                         outside;
	logic [WW:0]                  trial;
	logic [WW:0]                  trial_sub;
	logic                         trial_ge;
	logic [WW-1:0]                rem_next;
	logic signed [SUM_W-1:0]      sum_re;
	logic signed [SUM_W-1:0]      sum_im;

	assign pixels.ready = (state_q == F_IDLE);

	// width above the supported maximum is clamped
	assign width_ext = CMP_W'(cfg.side_len);
	assign width_eff = (width_ext > MAX_CMP) ? WW'(MAX_CMP) : WW'(width_ext);

	// bounds check against width squared
	assign width_sq = SQ_W'(width_q) * SQ_W'(width_q);
	assign outside  = CHK_W'(idx_q) >= CHK_W'(width_sq);

	// one restoring division step per cycle, quotient bits shift into quo_q
	assign trial     = {rem_q, quo_q[mep_pkg::INDEX_W-1]};
	assign trial_sub = trial - {1'b0, width_q};
	assign trial_ge  = trial >= {1'b0, width_q};
	assign rem_next  = trial_ge ? trial_sub[WW-1:0] : trial[WW-1:0];

	// point = origin + step * coordinate, saturated
	assign sum_re = SUM_W'($signed(cfg.real_origin)) + $signed(SUM_W'(prod_re_q));
	assign sum_im = SUM_W'($signed(cfg.imag_origin)) + $signed(SUM_W'(prod_im_q));

	assign job.pixel_index = idx_q;
	assign job.c_re        = mep_pkg::sat_coord(mep_pkg::SAT_W'(sum_re));
	assign job.c_im        = mep_pkg::sat_coord(mep_pkg::SAT_W'(sum_im));
	assign job_push        = (state_q == F_SUM) && !job_full;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			step_cnt_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (pixels.valid) begin
						state_q <= F_CHECK;
					end
				end
				F_CHECK: begin
					step_cnt_q <= '0;
					state_q    <= outside ? F_IDLE : F_DIV;
				end
				F_DIV: begin
					step_cnt_q <= step_cnt_q + CNT_W'(1);
					if (step_cnt_q == LAST_STEP) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					state_q <= F_SUM;
				end
				F_SUM: begin
					if (!job_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				idx_q   <= pixels.pixel_index;
				width_q <= width_eff;
			end
			F_CHECK: begin
				quo_q <= idx_q;
				rem_q <= '0;
			end
			F_DIV: begin
				quo_q <= {quo_q[mep_pkg::INDEX_W-2:0], trial_ge};
				rem_q <= rem_next;
			end
			F_MUL: begin
				prod_re_q <= PRD_W'(cfg.real_step) * PRD_W'(rem_q);
				prod_im_q <= PRD_W'(cfg.imag_step) * PRD_W'(quo_q[WW-1:0]);
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/mep_queue.sv */
module mep_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mep_pkg::job_t  push_job,
	output logic           full,
	input  logic           pop,
	output mep_pkg::job_t  pop_job,
	output logic           empty
);

	localparam int PTR_W = $clog2(mep_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(mep_pkg::QUEUE_DEPTH + 1);

	mep_pkg::job_t     entries [mep_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full    = (count_q == CNT_W'(mep_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = entries[rd_ptr_q];

	// pointers wrap naturally since the depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue fill count out of step");

endmodule

/* rtl/mep_back.sv */
module mep_back #(
	parameter int FRACTION_BITS = mep_pkg::FRACTION_BITS_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mep_pkg::cfg_t  cfg,
	input  mep_pkg::job_t  job,
	input  logic           job_empty,
	output logic           job_pop,
	mep_result_if.source   results
);

	localparam int PW        = mep_pkg::PROD_W;
	localparam int MAG_SHIFT = 2 * FRACTION_BITS + 2;
	localparam bit ESC_ON    = (MAG_SHIFT <= PW - 1);
	localparam logic [PW-1:0] MAG_LIMIT = ESC_ON ? (PW'(1) << MAG_SHIFT) : '0;

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_MUL  = 4'b0010,
		B_UPD  = 4'b0100,
		B_DONE = 4'b1000
	} back_state_t;

	back_state_t                          state_q;
	logic [mep_pkg::LIMIT_W-1:0]          iter_q;
	logic                                 out_valid_q;
	logic [mep_pkg::INDEX_W-1:0]          idx_q;
	logic signed [mep_pkg::COORD_W-1:0]   re_q;
	logic signed [mep_pkg::COORD_W-1:0]   im_q;
	logic signed [mep_pkg::COORD_W-1:0]   c_re_q;
	logic signed [mep_pkg::COORD_W-1:0]   c_im_q;
	logic signed [PW-1:0]                 sq_re_q;
	logic signed [PW-1:0]                 sq_im_q;
	logic signed [PW-1:0]                 cross_q;
	logic                                 esc_q;
	logic [mep_pkg::INDEX_W-1:0]          out_idx_q;
	logic                                 out_esc_q;

	logic [PW-1:0]                        mag;
	logic                                 esc_now;
	logic signed [PW-1:0]                 diff;
	logic signed [PW-1:0]                 sum_re;
	logic signed [PW-1:0]                 sum_im;
	logic signed [mep_pkg::COORD_W-1:0]   nre;
	logic signed [mep_pkg::COORD_W-1:0]   nim;
	logic                                 fixed_pt;
	logic [mep_pkg::LIMIT_W-1:0]          iter_next;
	logic                                 last_iter;
	logic                                 out_free;
	logic                                 out_load;

	assign job_pop = (state_q == B_IDLE) && !job_empty;

	// escape test on the registered squares
	assign mag     = $unsigned(sq_re_q) + $unsigned(sq_im_q);
	assign esc_now = ESC_ON && (mag > MAG_LIMIT);

	// next orbit point, floored and saturated
	assign diff   = sq_re_q - sq_im_q;
	assign sum_re = (diff >>> FRACTION_BITS) + PW'(c_re_q);
	assign sum_im = (cross_q >>> (FRACTION_BITS - 1)) + PW'(c_im_q);
	assign nre    = mep_pkg::sat_coord(mep_pkg::SAT_W'(sum_re));
	assign nim    = mep_pkg::sat_coord(mep_pkg::SAT_W'(sum_im));

	// an unchanged point can never escape
	assign fixed_pt  = (nre == re_q) && (nim == im_q);
	assign iter_next = iter_q + mep_pkg::LIMIT_W'(1);
	assign last_iter = (iter_next == cfg.iteration_limit);

	// result register
	assign out_free        = !out_valid_q || results.ready;
	assign out_load        = (state_q == B_DONE) && out_free;
	assign results.valid      = out_valid_q;
	assign results.pixel_echo = out_idx_q;
	assign results.escaped    = out_esc_q;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					iter_q <= '0;
					if (!job_empty) begin
						state_q <= (cfg.iteration_limit == '0) ? B_DONE : B_MUL;
					end
				end
				B_MUL: begin
					state_q <= B_UPD;
				end
				B_UPD: begin
					if (esc_now || fixed_pt || last_iter) begin
						state_q <= B_DONE;
					end else begin
						iter_q  <= iter_next;
						state_q <= B_MUL;
					end
				end
				B_DONE: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// orbit datapath
	always_ff @(posedge clk) begin
		if (job_pop) begin
			idx_q  <= job.pixel_index;
			re_q   <= job.c_re;
			im_q   <= job.c_im;
			c_re_q <= job.c_re;
			c_im_q <= job.c_im;
			esc_q  <= 1'b0;
		end
		if (state_q == B_MUL) begin
			sq_re_q <= PW'(re_q) * PW'(re_q);
			sq_im_q <= PW'(im_q) * PW'(im_q);
			cross_q <= PW'(re_q) * PW'(im_q);
		end
		if (state_q == B_UPD) begin
			esc_q <= esc_now;
			re_q  <= nre;
			im_q  <= nim;
		end
		if (out_load) begin
			out_idx_q <= idx_q;
			out_esc_q <= esc_q;
		end
	end

	a_upd_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_UPD) |-> ($past(state_q) == B_MUL))
		else $error("update without fresh products");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> ((state_q == B_MUL) || (state_q == B_DONE)))
		else $error("popped pixel not started");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == B_DONE) && !out_valid_q) |=> ((state_q == B_IDLE) && out_valid_q))
		else $error("finished pixel not moved to result register");

endmodule

/* rtl/mandelbrot_escape_pixel.sv */
// channel   direction  transaction carries
// pixels    in         pixel_index (20 bits)
// results   out        pixel_echo (20 bits), escaped (1 bit)
// cfg       in         cfg_index selects register, cfg_data written when cfg_we
//
// front: accept, bounds check (drops out-of-range indexes), 20 divide steps, multiply, sum
// back: each escape check is a three-product multiply state, then an update state
// sustained rate is set by the back at the default iteration limit
// reset restores the configuration defaults and empties the queue and result register
// a four-entry queue lets the front run ahead; the result register lets the back start
// the next pixel while an earlier result waits
module mandelbrot_escape_pixel #(
	parameter int MAX_WIDTH     = mep_pkg::MAX_WIDTH_DEFAULT,
	parameter int FRACTION_BITS = mep_pkg::FRACTION_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mep_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [mep_pkg::CFG_DATA_W-1:0]      cfg_data,
	mep_pixel_if.sink                           pixels,
	mep_result_if.source                        results
);

	mep_pkg::cfg_t  cfg_q;
	mep_pkg::job_t  push_job;
	mep_pkg::job_t  pop_job;
	logic           job_push;
	logic           job_full;
	logic           job_pop;
	logic           job_empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.iteration_limit <= mep_pkg::ITERATION_LIMIT_RESET;
			cfg_q.side_len        <= mep_pkg::SIDE_LEN_RESET;
			cfg_q.real_origin     <= mep_pkg::ORIGIN_RESET;
			cfg_q.imag_origin     <= mep_pkg::ORIGIN_RESET;
			cfg_q.real_step       <= mep_pkg::STEP_RESET;
			cfg_q.imag_step       <= mep_pkg::STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mep_pkg::REG_ITERATION_LIMIT: begin
					cfg_q.iteration_limit <= cfg_data[mep_pkg::LIMIT_W-1:0];
				end
				mep_pkg::REG_SIDE_LEN: begin
					cfg_q.side_len <= cfg_data[mep_pkg::WIDTH_W-1:0];
				end
				mep_pkg::REG_REAL_ORIGIN: begin
					cfg_q.real_origin <= cfg_data[mep_pkg::COORD_W-1:0];
				end
				mep_pkg::REG_IMAG_ORIGIN: begin
					cfg_q.imag_origin <= cfg_data[mep_pkg::COORD_W-1:0];
				end
				mep_pkg::REG_REAL_STEP: begin
					cfg_q.real_step <= cfg_data[mep_pkg::STEP_W-1:0];
				end
				mep_pkg::REG_IMAG_STEP: begin
					cfg_q.imag_step <= cfg_data[mep_pkg::STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// index split and point mapping
	mep_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pixels   (pixels),
		.job_push (job_push),
		.job      (push_job),
		.job_full (job_full)
	);

	// decoupling queue
	mep_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.full     (job_full),
		.pop      (job_pop),
		.pop_job  (pop_job),
		.empty    (job_empty)
	);

	// orbit iteration and result register
	mep_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (pop_job),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.results   (results)
	);

endmodule
